/* rtl/etfi_pkg.sv */
// Shared types, register indexes and fixed-point helpers for the escape-time
// fractal iterator. No dependencies; every other file refers to this package.
`default_nettype none

package etfi_pkg;

  // Q8.40 plane coordinates in 48 bits.
  localparam int QW = 48;
  localparam int FracW = 40;
  // Truncated product of two Q.40 magnitudes of at most 2^47: at most 2^54.
  localparam int ProdW = 55;
  // zr^2 + zi^2 at Q.40.
  localparam int MagW = 56;
  // Width of the intermediate sums before saturation.
  localparam int WideW = 62;
  // Signed width of 2*pixel - IMAGE_SIZE.
  localparam int OffW = 14;

  localparam int QueueDepth = 2;
  localparam int QueuePtrW = 1;
  localparam int QueueCntW = 2;

  localparam logic signed [QW-1:0] QMax = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [QW-1:0] QMin = 48'sh8000_0000_0000;

  // Configuration register indexes.
  localparam logic [2:0] RegFractalMode = 3'd0;
  localparam logic [2:0] RegMaxIterations = 3'd1;
  localparam logic [2:0] RegBailLimit = 3'd2;
  localparam logic [2:0] RegPixelStep = 3'd3;
  localparam logic [2:0] RegCenterReal = 3'd4;
  localparam logic [2:0] RegCenterImag = 3'd5;
  localparam logic [2:0] RegJuliaReal = 3'd6;
  localparam logic [2:0] RegJuliaImag = 3'd7;

  // Fractal mode codes; the unused fourth code runs as Mandelbrot.
  localparam logic [1:0] ModeMandel = 2'd0;
  localparam logic [1:0] ModeShip = 2'd1;
  localparam logic [1:0] ModeJulia = 2'd2;

  typedef struct packed {
    logic [1:0]             fractal_mode;
    logic [15:0]            max_iterations;
    logic [6:0]             bail_limit;
    logic [46:0]            pixel_step;
    logic signed [QW-1:0]   center_real;
    logic signed [QW-1:0]   center_imag;
    logic signed [QW-1:0]   julia_real;
    logic signed [QW-1:0]   julia_imag;
  } cfg_t;

  typedef struct packed {
    logic signed [QW-1:0] pr;
    logic signed [QW-1:0] pi;
  } coord_t;

  typedef enum logic [1:0] {
    PROD_SQR   = 2'd0,
    PROD_SQI   = 2'd1,
    PROD_CROSS = 2'd2
  } prod_sel_t;

  typedef struct packed {
    logic          valid;
    logic [QW-1:0] a;
    logic [QW-1:0] b;
    prod_sel_t     tag;
  } mul_req_t;

  typedef struct packed {
    logic             valid;
    logic [ProdW-1:0] p;
    prod_sel_t        tag;
  } mul_res_t;

  // Clamp a wide signed value to the signed 48-bit range.
  function automatic logic signed [QW-1:0] sat_q(input logic signed [WideW-1:0] v);
    logic signed [QW-1:0] r;
    if ((&v[WideW-1:QW-1]) || !(|v[WideW-1:QW-1])) begin
      r = v[QW-1:0];
    end else if (v[WideW-1]) begin
      r = QMin;
    end else begin
      r = QMax;
    end
    return r;
  endfunction

  // Magnitude of a signed 48-bit value; the most negative value gives 2^47.
  function automatic logic [QW-1:0] mag_q(input logic signed [QW-1:0] v);
    logic [QW-1:0] r;
    r = v[QW-1] ? QW'(-v) : QW'(v);
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/etfi_mul48.sv */
// Two-stage 48x48 unsigned multiplier built from four 24x24 partial products,
// returning the product shifted right by 40 bits. Uses etfi_pkg.
`default_nettype none

module etfi_mul48 (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire etfi_pkg::mul_req_t req,
  output etfi_pkg::mul_res_t      res
);

  logic [47:0]         hh_r, hl_r, lh_r, ll_r;
  logic                v1_r;
  etfi_pkg::prod_sel_t tag1_r;
  logic [95:0]         full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= req.valid;
    end
    tag1_r <= req.tag;
    hh_r <= req.a[47:24] * req.b[47:24];
    hl_r <= req.a[47:24] * req.b[23:0];
    lh_r <= req.a[23:0] * req.b[47:24];
    ll_r <= req.a[23:0] * req.b[23:0];
  end

  assign full = {hh_r, 48'b0} + {24'b0, hl_r, 24'b0} + {24'b0, lh_r, 24'b0}
              + {48'b0, ll_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= v1_r;
    end
    res.tag <= tag1_r;
    res.p <= full[etfi_pkg::FracW +: etfi_pkg::ProdW];
  end

endmodule

`default_nettype wire

/* rtl/etfi_front.sv */
// Front end: accepts pixel coordinates and maps them to the complex plane in
// signed Q8.40 over two register stages. Uses etfi_pkg.
`default_nettype none

module etfi_front #(
  parameter int IMAGE_SIZE = 4096
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [11:0]               pixel_x,
  input  wire logic [11:0]               pixel_y,
  input  wire logic [46:0]               pixel_step,
  input  wire logic signed [47:0]        center_real,
  input  wire logic signed [47:0]        center_imag,
  input  wire logic                      q_full,
  output logic                           q_push,
  output etfi_pkg::coord_t               q_data
);

  logic                               s1_valid_r, s2_valid_r;
  logic [11:0]                        px_r, py_r;
  logic signed [38:0]                 plo_x_r, plo_y_r;
  logic signed [37:0]                 phi_x_r, phi_y_r;
  logic signed [etfi_pkg::OffW-1:0]   off_x, off_y;
  logic signed [24:0]                 step_lo;
  logic signed [23:0]                 step_hi;
  logic                               s1_move, s2_move;

  function automatic logic signed [etfi_pkg::OffW-1:0] offset2(input logic [11:0] pix);
    logic signed [etfi_pkg::OffW-1:0] r;
    r = $signed({1'b0, pix, 1'b0}) - $signed(etfi_pkg::OffW'(IMAGE_SIZE));
    return r;
  endfunction

  // Full product (off2 * step) / 2 rounded toward zero, plus center, clamped.
  function automatic logic signed [47:0] finish_coord(input logic signed [38:0] plo,
                                                      input logic signed [37:0] phi,
                                                      input logic signed [47:0] center);
    logic signed [etfi_pkg::WideW-1:0] prod, tmp, half, sum;
    prod = {{(etfi_pkg::WideW - 62){1'b0}}, {phi, 24'b0}}
         + {{(etfi_pkg::WideW - 39){plo[38]}}, plo};
    tmp = prod + {{(etfi_pkg::WideW - 1){1'b0}}, prod[etfi_pkg::WideW-1]};
    half = tmp >>> 1;
    sum = half + {{(etfi_pkg::WideW - 48){center[47]}}, center};
    return etfi_pkg::sat_q(sum);
  endfunction

  assign off_x = offset2(px_r);
  assign off_y = offset2(py_r);
  assign step_lo = $signed({1'b0, pixel_step[23:0]});
  assign step_hi = $signed({1'b0, pixel_step[46:24]});

  assign s2_move = s2_valid_r && !q_full;
  assign s1_move = s1_valid_r && (!s2_valid_r || s2_move);
  assign in_ready = !s1_valid_r || s1_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        s2_valid_r <= 1'b1;
      end else if (s2_move) begin
        s2_valid_r <= 1'b0;
      end
    end
    if (in_valid && in_ready) begin
      px_r <= pixel_x;
      py_r <= pixel_y;
    end
    if (s1_move) begin
      plo_x_r <= off_x * step_lo;
      phi_x_r <= off_x * step_hi;
      plo_y_r <= off_y * step_lo;
      phi_y_r <= off_y * step_hi;
    end
  end

  assign q_push = s2_move;
  assign q_data.pr = finish_coord(plo_x_r, phi_x_r, center_real);
  assign q_data.pi = finish_coord(plo_y_r, phi_y_r, center_imag);

endmodule

`default_nettype wire

/* rtl/etfi_queue.sv */
// Short queue of mapped coordinates between the front end and the iteration
// engine. Uses etfi_pkg for the entry type and depth.
`default_nettype none

module etfi_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire etfi_pkg::coord_t push_data,
  input  wire logic             pop,
  output etfi_pkg::coord_t      head,
  output logic                  full,
  output logic                  empty
);

  etfi_pkg::coord_t                 mem [etfi_pkg::QueueDepth];
  logic [etfi_pkg::QueuePtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [etfi_pkg::QueueCntW-1:0]   count_r;

  assign full = (count_r == etfi_pkg::QueueCntW'(etfi_pkg::QueueDepth));
  assign empty = (count_r == '0);
  assign head = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue read while empty");

endmodule

`default_nettype wire

/* rtl/etfi_back.sv */
// Iteration engine: takes mapped points from the queue, iterates the selected
// quadratic map on the shared product unit and holds the result for transfer.
// Uses etfi_pkg and etfi_mul48.
`default_nettype none

module etfi_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire etfi_pkg::cfg_t   cfg,
  input  wire etfi_pkg::coord_t q_head,
  input  wire logic             q_empty,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [15:0]           out_iteration_count,
  output logic                  out_escaped,
  output logic [39:0]           out_magnitude_sq
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ISSUE = 5'b00010,
    S_WAIT  = 5'b00100,
    S_CHECK = 5'b01000,
    S_DONE  = 5'b10000
  } back_state_t;

  back_state_t                       state_r, state_nxt;
  logic [1:0]                        iss_r;
  logic signed [etfi_pkg::QW-1:0]    zr_r, zi_r, cr_r, ci_r;
  logic [etfi_pkg::ProdW-1:0]        sqr_r, sqi_r, cross_r;
  logic [etfi_pkg::MagW-1:0]         mag_r;
  logic [15:0]                       count_r;
  logic                              iter_r, esc_r;
  logic                              out_valid_r;

  etfi_pkg::mul_req_t                mreq;
  etfi_pkg::mul_res_t                mres;

  logic                              is_ship, is_julia, is_mandel;
  logic [etfi_pkg::MagW-1:0]         bail_q;
  logic                              mag_ge, mag_gt, esc_after, at_limit;
  logic                              finish, finish_esc;
  logic signed [etfi_pkg::WideW-1:0] sqr_ext, sqi_ext, cross_ext, cross_s;
  logic signed [etfi_pkg::WideW-1:0] cr_ext, ci_ext, nr, ni;
  logic                              cross_neg;

  etfi_mul48 u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .res   (mres)
  );

  assign is_ship = (cfg.fractal_mode == etfi_pkg::ModeShip);
  assign is_julia = (cfg.fractal_mode == etfi_pkg::ModeJulia);
  assign is_mandel = !is_ship && !is_julia;

  // Three products per iteration: zr^2, zi^2 and |zr|*|zi|, one per cycle.
  always_comb begin
    mreq.valid = (state_r == S_ISSUE);
    mreq.a = etfi_pkg::mag_q(zr_r);
    mreq.b = etfi_pkg::mag_q(zr_r);
    mreq.tag = etfi_pkg::PROD_SQR;
    case (iss_r)
      2'd0: begin
        mreq.tag = etfi_pkg::PROD_SQR;
      end
      2'd1: begin
        mreq.a = etfi_pkg::mag_q(zi_r);
        mreq.b = etfi_pkg::mag_q(zi_r);
        mreq.tag = etfi_pkg::PROD_SQI;
      end
      default: begin
        mreq.b = etfi_pkg::mag_q(zi_r);
        mreq.tag = etfi_pkg::PROD_CROSS;
      end
    endcase
  end

  assign bail_q = {9'b0, cfg.bail_limit, 40'b0};
  assign mag_ge = (mag_r >= bail_q);
  assign mag_gt = (mag_r > bail_q);
  // Modes 1 and 2 test after an iteration, never on the starting point.
  assign esc_after = iter_r && ((is_ship && mag_ge) || (is_julia && mag_gt));
  assign at_limit = (count_r >= cfg.max_iterations);
  assign finish = esc_after || at_limit || (is_mandel && mag_ge);
  assign finish_esc = esc_after || (is_mandel && mag_ge);

  assign sqr_ext = {{(etfi_pkg::WideW - etfi_pkg::ProdW){1'b0}}, sqr_r};
  assign sqi_ext = {{(etfi_pkg::WideW - etfi_pkg::ProdW){1'b0}}, sqi_r};
  assign cross_ext = {{(etfi_pkg::WideW - etfi_pkg::ProdW){1'b0}}, cross_r};
  assign cr_ext = {{(etfi_pkg::WideW - etfi_pkg::QW){cr_r[etfi_pkg::QW-1]}}, cr_r};
  assign ci_ext = {{(etfi_pkg::WideW - etfi_pkg::QW){ci_r[etfi_pkg::QW-1]}}, ci_r};
  // The burning-ship cross term uses magnitudes only.
  assign cross_neg = !is_ship && (zr_r[etfi_pkg::QW-1] != zi_r[etfi_pkg::QW-1]);
  assign cross_s = cross_neg ? -cross_ext : cross_ext;
  assign nr = is_ship ? (sqr_ext - sqi_ext - cr_ext) : (sqr_ext - sqi_ext + cr_ext);
  assign ni = (cross_s <<< 1) + ci_ext;

  assign q_pop = (state_r == S_IDLE) && !q_empty;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (iss_r == 2'd2) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (mres.valid && mres.tag == etfi_pkg::PROD_CROSS) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = finish ? S_DONE : S_ISSUE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iss_r <= 2'd0;
      count_r <= 16'd0;
      iter_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_ISSUE) begin
        iss_r <= (iss_r == 2'd2) ? 2'd0 : iss_r + 2'd1;
      end
      if (q_pop) begin
        count_r <= 16'd0;
        iter_r <= 1'b0;
      end else if (state_r == S_CHECK && !finish) begin
        count_r <= count_r + 16'd1;
        iter_r <= 1'b1;
      end
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (is_julia) begin
        zr_r <= q_head.pr;
        zi_r <= q_head.pi;
        cr_r <= cfg.julia_real;
        ci_r <= cfg.julia_imag;
      end else begin
        zr_r <= '0;
        zi_r <= '0;
        cr_r <= q_head.pr;
        ci_r <= q_head.pi;
      end
    end else if (state_r == S_CHECK && !finish) begin
      zr_r <= etfi_pkg::sat_q(nr);
      zi_r <= etfi_pkg::sat_q(ni);
    end
    if (state_r == S_CHECK) begin
      esc_r <= finish_esc;
    end
    if (mres.valid) begin
      case (mres.tag)
        etfi_pkg::PROD_SQR: begin
          sqr_r <= mres.p;
        end
        etfi_pkg::PROD_SQI: begin
          sqi_r <= mres.p;
          // zr^2 landed the cycle before.
          mag_r <= {1'b0, sqr_r} + {1'b0, mres.p};
        end
        default: begin
          cross_r <= mres.p;
        end
      endcase
    end
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_iteration_count <= count_r;
      out_escaped <= esc_r;
      // |z|^2 stays below 2^56 at Q.40, so the Q16.24 form never saturates.
      out_magnitude_sq <= mag_r[etfi_pkg::MagW-1:16];
    end
  end

  assign out_valid = out_valid_r;

  a_result_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    mres.valid |-> (state_r == S_ISSUE || state_r == S_WAIT))
    else $error("product returned outside of the iteration step");

  a_check_after_cross: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> $past(mres.valid && mres.tag == etfi_pkg::PROD_CROSS))
    else $error("escape check ran before all products arrived");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ISSUE && $past(state_r) == S_CHECK) |-> count_r == $past(count_r) + 16'd1)
    else $error("iteration count did not advance with the point");

endmodule

`default_nettype wire

/* rtl/escape_time_fractal_iterator.sv */
// Top level of the escape-time fractal iterator: configuration registers,
// front end, coordinate queue and iteration engine. Uses etfi_pkg and all etfi_* modules.
//
//   Channel   Direction  Handshake              Payload
//   in_       input      in_valid / in_ready    pixel_x, pixel_y
//   out_      output     out_valid / out_ready  iteration_count, escaped, magnitude_sq
//   cfg_      input      cfg_we                 cfg_addr, cfg_wdata
//
// Each iteration issues three products through the one shared 48x48 product unit,
// waits for them, then runs the escape test and update. While the engine iterates
// one pixel, the front end maps the next pixel into the queue.
// Reset is synchronous, active low, and restores the register defaults.
// A stalled result waits in the output register; the queue keeps accepting pixels until it is full.
`default_nettype none

module escape_time_fractal_iterator #(
  parameter int IMAGE_SIZE = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [11:0] in_pixel_x,
  input  wire logic [11:0] in_pixel_y,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_iteration_count,
  output logic             out_escaped,
  output logic [39:0]      out_magnitude_sq,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [47:0] cfg_wdata
);

  etfi_pkg::cfg_t   cfg_r;
  etfi_pkg::coord_t q_in, q_head;
  logic             q_push, q_pop, q_full, q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fractal_mode <= etfi_pkg::ModeMandel;
      cfg_r.max_iterations <= 16'd50;
      cfg_r.bail_limit <= 7'd4;
      cfg_r.pixel_step <= 47'd3665038759;
      cfg_r.center_real <= '0;
      cfg_r.center_imag <= '0;
      cfg_r.julia_real <= '0;
      cfg_r.julia_imag <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        etfi_pkg::RegFractalMode: cfg_r.fractal_mode <= cfg_wdata[1:0];
        etfi_pkg::RegMaxIterations: cfg_r.max_iterations <= cfg_wdata[15:0];
        etfi_pkg::RegBailLimit: cfg_r.bail_limit <= cfg_wdata[6:0];
        etfi_pkg::RegPixelStep: cfg_r.pixel_step <= cfg_wdata[46:0];
        etfi_pkg::RegCenterReal: cfg_r.center_real <= cfg_wdata;
        etfi_pkg::RegCenterImag: cfg_r.center_imag <= cfg_wdata;
        etfi_pkg::RegJuliaReal: cfg_r.julia_real <= cfg_wdata;
        etfi_pkg::RegJuliaImag: cfg_r.julia_imag <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  etfi_front #(
    .IMAGE_SIZE (IMAGE_SIZE)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel_x     (in_pixel_x),
    .pixel_y     (in_pixel_y),
    .pixel_step  (cfg_r.pixel_step),
    .center_real (cfg_r.center_real),
    .center_imag (cfg_r.center_imag),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_in)
  );

  etfi_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  etfi_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .q_head              (q_head),
    .q_empty             (q_empty),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_iteration_count (out_iteration_count),
    .out_escaped         (out_escaped),
    .out_magnitude_sq    (out_magnitude_sq)
  );

endmodule

`default_nettype wire
